>>> rtl/amt_pkg.sv
// Package: shared types, constants and helpers for the identifier match table.
`timescale 1ns / 1ps
package amt_pkg;

    // Table sizing
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > 4) ? CNT_W : 4;

    // Identifier geometry: one byte moves per cycle
    localparam int AID_BYTES  = 16;
    localparam int BYTE_W     = 8;
    localparam int AID_W      = AID_BYTES * BYTE_W;
    localparam int BIDX_W     = $clog2(AID_BYTES);
    localparam int PH_W       = $clog2(AID_BYTES + 1);
    localparam int BYTE_DEPTH = MAX_ENTRIES * AID_BYTES;
    localparam int BYTE_AW    = $clog2(BYTE_DEPTH);

    localparam logic [PH_W-1:0] LAST_PHASE = PH_W'(AID_BYTES);
    localparam logic [4:0] AID_MIN_LEN = 5'd5;
    localparam logic [4:0] AID_MAX_LEN = 5'd16;

    // Function codes
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_SET    = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [1:0] FUNC_CLEAR  = 2'd3;

    // Match modes
    localparam logic [1:0] MODE_EXACT   = 2'd0;
    localparam logic [1:0] MODE_PARTIAL = 2'd1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] aid_upper;
        logic [63:0] aid_lower;
        logic [4:0]  aid_length;
        logic [1:0]  match_mode;
        logic [3:0]  entry_index;
        logic        enable_flag;
    } amt_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       supported;
        logic [3:0] new_entry;
    } amt_out_t;

    // Per-entry attributes kept beside the byte store
    typedef struct packed {
        logic [4:0] length;
        logic [1:0] mode;
    } amt_attr_t;

    // Scan control from the sequencer to the byte comparator
    typedef struct packed {
        logic              clr;
        logic              cmp;
        logic              last;
        logic [BIDX_W-1:0] bidx;
    } amt_scan_ctl_t;

    // Byte store address: entry index above byte index
    function automatic logic [BYTE_AW-1:0] byte_addr(input logic [IDX_W-1:0] e,
                                                     input logic [BIDX_W-1:0] b);
        return BYTE_AW'({e, b});
    endfunction

endpackage

>>> rtl/amt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module amt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

>>> rtl/amt_qshift.sv
// Query shift register: loads an identifier and rotates it out one byte per cycle while shift is high.
`timescale 1ns / 1ps
module amt_qshift (
    input  logic              aclk,
    input  logic              load,
    input  logic              shift,
    input  logic [63:0]       aid_upper,
    input  logic [63:0]       aid_lower,
    output logic [amt_pkg::BYTE_W-1:0] top_byte
);
    import amt_pkg::*;

    logic [AID_W-1:0] data_reg;
    logic [AID_W-1:0] data_next;

    // Load the query, or rotate left by one byte so the word comes back after a full pass
    always_comb begin
        data_next = data_reg;
        if (load) begin
            data_next = {aid_upper, aid_lower};
        end else if (shift) begin
            data_next = {data_reg[AID_W-BYTE_W-1:0], data_reg[AID_W-1 -: BYTE_W]};
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign top_byte = data_reg[AID_W-1 -: BYTE_W];
endmodule

>>> rtl/amt_match.sv
// Byte-serial comparator: folds one byte compare per cycle, on each compare beat, into an entry match.
`timescale 1ns / 1ps
module amt_match (
    input  logic                          aclk,
    input  amt_pkg::amt_scan_ctl_t        ctl,
    input  logic [amt_pkg::BYTE_W-1:0]    stored_byte,
    input  logic [amt_pkg::BYTE_W-1:0]    query_byte,
    input  amt_pkg::amt_attr_t            attr,
    input  logic                          disabled,
    input  logic [4:0]                    query_length,
    output logic                          hit
);
    import amt_pkg::*;

    logic eq_reg;
    logic eq_next;
    logic byte_ok;
    logic eq_all;
    logic len_ok;

    // Bytes past the stored length always pass
    assign byte_ok = ({1'b0, ctl.bidx} >= attr.length) || (stored_byte == query_byte);
    assign eq_all  = eq_reg & byte_ok;

    // Restart at each entry, accumulate on every compare beat
    always_comb begin
        eq_next = eq_reg;
        if (ctl.clr) begin
            eq_next = 1'b1;
        end else if (ctl.cmp) begin
            eq_next = eq_all;
        end
    end

    always_ff @(posedge aclk) begin
        eq_reg <= eq_next;
    end

    // Length rule by mode; other modes never match
    always_comb begin
        len_ok = 1'b0;
        if (attr.mode == MODE_EXACT) begin
            len_ok = (attr.length == query_length);
        end else if (attr.mode == MODE_PARTIAL) begin
            len_ok = (attr.length <= query_length);
        end
    end

    assign hit = ctl.last && !disabled && eq_all && len_ok;
endmodule

>>> rtl/aid_match_table_top.sv
// Top level: identifier match table with byte-serial store and lookup.
//
//  channel | ports             | payload   | handshake
//  --------+-------------------+-----------+-----------------
//  input   | s_valid s_ready   | s_data    | valid / ready
//  result  | m_valid m_ready   | m_data    | valid / ready
//
// Path from acceptance to m_valid, the move into the output register included: clear and
// rejected add via S_OUT, set enable via S_SET and S_OUT, add via S_ADD (one byte written
// per cycle), lookup via S_SCAN (one stored byte read and compared per cycle, set by the
// single read port of the byte store), stopping at the first hit; s_ready returns with m_valid.
// Reset clears the entry count and control; table contents are never read before written.
// A stalled result waits in the output register while the next beat is taken.
`timescale 1ns / 1ps
module aid_match_table_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  amt_pkg::amt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output amt_pkg::amt_out_t m_data
);
    import amt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADD  = 5'b00010,
        S_SET  = 5'b00100,
        S_SCAN = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  scan_e_reg, scan_e_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [4:0]        qlen_reg, qlen_next;
    logic [1:0]        mode_reg, mode_next;
    logic [3:0]        idx_reg, idx_next;
    logic              en_reg, en_next;
    amt_out_t          res_reg, res_next;
    amt_out_t          m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;

    logic              accept;
    logic              q_shift;
    logic [BYTE_W-1:0] q_byte;
    logic [BYTE_W-1:0] s_byte;
    amt_attr_t         attr_rd;
    amt_attr_t         attr_wr;
    logic              dis_rd;
    logic              dis_we;
    logic [IDX_W-1:0]  dis_waddr;
    logic              dis_wdata;
    logic              byte_we;
    logic              attr_we;
    logic [IDX_W-1:0]  add_e;
    amt_scan_ctl_t     scan_ctl;
    logic              hit;
    logic              scan_end;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign add_e  = IDX_W'(count_reg);

    // Query bytes stream from here for both add and lookup
    amt_qshift u_qshift (
        .aclk      (aclk),
        .load      (accept),
        .shift     (q_shift),
        .aid_upper (s_data.aid_upper),
        .aid_lower (s_data.aid_lower),
        .top_byte  (q_byte)
    );

    // Identifier bytes, one per address
    amt_ram #(.WIDTH(BYTE_W), .DEPTH(BYTE_DEPTH)) u_byte_ram (
        .aclk    (aclk),
        .wr_en   (byte_we),
        .wr_addr (byte_addr(add_e, phase_reg[BIDX_W-1:0])),
        .wr_data (q_byte),
        .rd_addr (byte_addr(scan_e_reg, phase_reg[BIDX_W-1:0])),
        .rd_data (s_byte)
    );

    // Length and mode per entry
    amt_ram #(.WIDTH($bits(amt_attr_t)), .DEPTH(MAX_ENTRIES)) u_attr_ram (
        .aclk    (aclk),
        .wr_en   (attr_we),
        .wr_addr (add_e),
        .wr_data (attr_wr),
        .rd_addr (scan_e_reg),
        .rd_data (attr_rd)
    );

    // Disabled mark per entry
    amt_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_dis_ram (
        .aclk    (aclk),
        .wr_en   (dis_we),
        .wr_addr (dis_waddr),
        .wr_data (dis_wdata),
        .rd_addr (scan_e_reg),
        .rd_data (dis_rd)
    );

    amt_match u_match (
        .aclk         (aclk),
        .ctl          (scan_ctl),
        .stored_byte  (s_byte),
        .query_byte   (q_byte),
        .attr         (attr_rd),
        .disabled     (dis_rd),
        .query_length (qlen_reg),
        .hit          (hit)
    );

    // Scan control: phase 0 issues the first read, phases 1..16 compare
    always_comb begin
        scan_ctl.clr  = (state_reg == S_SCAN) && (phase_reg == '0);
        scan_ctl.cmp  = (state_reg == S_SCAN) && (phase_reg != '0);
        scan_ctl.last = (state_reg == S_SCAN) && (phase_reg == LAST_PHASE);
        scan_ctl.bidx = BIDX_W'(phase_reg - PH_W'(1));
    end

    assign scan_end = (CNT_W'(scan_e_reg) + CNT_W'(1)) == count_reg;

    assign attr_wr.length = qlen_reg;
    assign attr_wr.mode   = mode_reg;

    // Store write strobes
    always_comb begin
        byte_we   = (state_reg == S_ADD);
        attr_we   = (state_reg == S_ADD) && (phase_reg == '0);
        dis_we    = attr_we;
        dis_waddr = add_e;
        dis_wdata = 1'b0;
        q_shift   = byte_we || scan_ctl.cmp;
        if ((state_reg == S_SET) &&
            (CMP_W'(idx_reg) < CMP_W'(count_reg))) begin
            dis_we    = 1'b1;
            dis_waddr = IDX_W'(idx_reg);
            dis_wdata = !en_reg;
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_e_next  = scan_e_reg;
        phase_next   = phase_reg;
        qlen_next    = qlen_reg;
        mode_next    = mode_reg;
        idx_next     = idx_reg;
        en_next      = en_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        // Drop the output beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    qlen_next = s_data.aid_length;
                    mode_next = s_data.match_mode;
                    idx_next  = s_data.entry_index;
                    en_next   = s_data.enable_flag;
                    res_next  = '{status: ST_OK, supported: 1'b0, new_entry: 4'd0};
                    phase_next  = '0;
                    scan_e_next = '0;
                    unique case (s_data.func)
                        FUNC_ADD: begin
                            if ((s_data.aid_length < AID_MIN_LEN) ||
                                (s_data.aid_length > AID_MAX_LEN)) begin
                                res_next.status = ST_INVALID;
                                state_next      = S_OUT;
                            end else if (count_reg == CNT_W'(MAX_ENTRIES)) begin
                                res_next.status = ST_FULL;
                                state_next      = S_OUT;
                            end else begin
                                state_next = S_ADD;
                            end
                        end
                        FUNC_SET: begin
                            state_next = S_SET;
                        end
                        FUNC_LOOKUP: begin
                            state_next = (count_reg == '0) ? S_OUT : S_SCAN;
                        end
                        FUNC_CLEAR: begin
                            count_next = '0;
                            state_next = S_OUT;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_ADD: begin
                // Write one byte per cycle, then bump the count
                phase_next = phase_reg + PH_W'(1);
                if (phase_reg == LAST_PHASE - PH_W'(1)) begin
                    count_next         = count_reg + CNT_W'(1);
                    res_next.new_entry = 4'(count_reg);
                    state_next         = S_OUT;
                end
            end
            S_SET: begin
                if (CMP_W'(idx_reg) >= CMP_W'(count_reg)) begin
                    res_next.status = ST_INVALID;
                end
                state_next = S_OUT;
            end
            S_SCAN: begin
                // Advance through bytes, then through entries
                if (phase_reg == LAST_PHASE) begin
                    phase_next = '0;
                    if (hit) begin
                        res_next.supported = 1'b1;
                        state_next         = S_OUT;
                    end else if (scan_end) begin
                        state_next = S_OUT;
                    end else begin
                        scan_e_next = scan_e_reg + IDX_W'(1);
                    end
                end else begin
                    phase_next = phase_reg + PH_W'(1);
                end
            end
            S_OUT: begin
                // Hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_e_reg <= scan_e_next;
        phase_reg  <= phase_next;
        qlen_reg   <= qlen_next;
        mode_reg   <= mode_next;
        idx_reg    <= idx_next;
        en_reg     <= en_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
